// ----- rtl/wia_pkg.sv -----
// Shared types and constants of the wide integer accumulator.
`default_nettype none

package wia_pkg;

    localparam int DIGIT_W     = 32;
    localparam int POS_W       = 7;
    localparam int SHAMT_W     = 6;
    localparam int NPOS_W      = POS_W + 1;
    localparam int DIGITS_DEF  = 128;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 40;
    localparam logic [SHAMT_W-1:0] SHAMT_MAX = SHAMT_W'(DIGIT_W);

    typedef enum logic [2:0] {
        OP_SET64     = 3'd0,
        OP_SETDCLR   = 3'd1,
        OP_ADD64     = 3'd2,
        OP_INC       = 3'd3,
        OP_ADDDIGIT  = 3'd4,
        OP_SHL       = 3'd5,
        OP_SHR       = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_OVF = 2'd1,
        STAT_BAD = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SHL = 2'd1,
        ALU_SHR = 2'd2
    } alu_kind_t;

    typedef struct packed {
        alu_kind_t          kind;
        logic [SHAMT_W-1:0] shamt;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/wia_digit_ram.sv -----
// Digit store: one write port, one read port, registered read data.
`default_nettype none

module wia_digit_ram
    import wia_pkg::*;
#(
    parameter int DEPTH = DIGITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [DIGIT_W-1:0] wdata,
    input  wire logic [AW-1:0]      raddr,
    output logic      [DIGIT_W-1:0] rdata
);

    logic [DIGIT_W-1:0] mem [DEPTH];

    // write and read the array
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/wia_digit_alu.sv -----
// Per-digit datapath: add with carry, shift left or right with carried bits.
`default_nettype none

module wia_digit_alu
    import wia_pkg::*;
(
    input  wire alu_ctrl_t          ctrl,
    input  wire logic [DIGIT_W-1:0] digit,
    input  wire logic [DIGIT_W-1:0] term,
    input  wire logic [DIGIT_W-1:0] carry_in,
    output logic      [DIGIT_W-1:0] digit_new,
    output logic      [DIGIT_W-1:0] carry_out
);

    logic [DIGIT_W:0]     sum;
    logic [2*DIGIT_W-1:0] shl_w;
    logic [2*DIGIT_W-1:0] shr_w;

    assign sum   = {1'b0, digit} + {1'b0, term} + {{DIGIT_W{1'b0}}, carry_in[0]};
    assign shl_w = {{DIGIT_W{1'b0}}, digit} << ctrl.shamt;
    assign shr_w = {digit, {DIGIT_W{1'b0}}} >> ctrl.shamt;

    // select the result of the requested digit operation
    always_comb begin
        case (ctrl.kind)
            ALU_ADD: begin
                digit_new = sum[DIGIT_W-1:0];
                carry_out = {{(DIGIT_W-1){1'b0}}, sum[DIGIT_W]};
            end
            ALU_SHL: begin
                digit_new = shl_w[DIGIT_W-1:0] | carry_in;
                carry_out = shl_w[2*DIGIT_W-1:DIGIT_W];
            end
            ALU_SHR: begin
                digit_new = shr_w[2*DIGIT_W-1:DIGIT_W] | carry_in;
                carry_out = shr_w[DIGIT_W-1:0];
            end
            default: begin
                digit_new = digit;
                carry_out = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/wide_integer_accumulator.sv -----
// Wide integer accumulator: sequencer, output register and digit store.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser op, tdata position/value/shift, tlast
//  m_      | out | m_tvalid/m_tready  | tdata digit/top, tuser status
//
// One item at a time. Every add or shift digit step is one read-modify-write of the
// store, one digit per cycle with the read of the next digit overlapping the write.
// Add and increment walk the digits the carry touches; shifts walk the digits up to
// the top; set-digit-and-clear writes digits 0 to the position; each result then
// passes through a finishing state into the output register.
// Reset is synchronous and needs no sweep: only digit 0 carries a valid flag.
// A result waiting on m_ stalls the sequencer only when the next one is done.
`default_nettype none

module wide_integer_accumulator
    import wia_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [6:0] position, [70:7] operand_value, [76:71] shift_amount, rest zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] op
    input  wire logic [2:0]           s_tuser,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] digit_out, [38:32] top_out, [39] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [1:0]                m_tuser
);

    localparam int AW = $clog2(DIGITS);
    localparam logic [AW-1:0] IDX_MAX = AW'(DIGITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SETW, S_CLRW, S_ADDW, S_SHLW, S_SHLX, S_SHRW, S_READW, S_FIN
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       top_reg;
    logic [DIGIT_W-1:0]  term_reg;
    logic [DIGIT_W-1:0]  hi_reg;
    logic [DIGIT_W-1:0]  carry_reg;
    logic [SHAMT_W-1:0]  shamt_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                last_reg;
    logic                tz_reg;
    logic                d0_ok_reg;
    logic                scarry_reg;
    logic [NPOS_W-1:0]   npos_reg;
    logic [DIGIT_W-1:0]  dout_reg;
    stat_t               stat_reg;
    logic                m_valid_reg;
    logic [DIGIT_W-1:0]  m_digit_reg;
    logic [POS_W-1:0]    m_top_reg;
    stat_t               m_stat_reg;

    op_t                 in_op;
    logic [POS_W-1:0]    in_pos;
    logic [63:0]         in_val;
    logic [SHAMT_W-1:0]  in_sh;
    logic                pos_ok;
    logic                sh_bad;
    logic                in_bad;
    state_t              in_state;
    logic [AW-1:0]       in_idx;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [DIGIT_W-1:0]  mem_wd;
    logic [AW-1:0]       mem_ra;
    logic [DIGIT_W-1:0]  mem_rd;
    logic [DIGIT_W-1:0]  rd_eff;
    alu_ctrl_t           alu_ctrl;
    logic [DIGIT_W-1:0]  alu_new;
    logic [DIGIT_W-1:0]  alu_cout;
    logic                out_free;

    // unpack the input beat
    assign in_op  = op_t'(s_tuser);
    assign in_pos = s_tdata[6:0];
    assign in_val = s_tdata[70:7];
    assign in_sh  = s_tdata[76:71];
    assign pos_ok = 32'(in_pos) < 32'(DIGITS);
    assign sh_bad = in_sh > SHAMT_MAX;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // classify the offered beat: first state, start digit and rejection
    always_comb begin
        in_bad   = 1'b0;
        in_state = S_RD;
        in_idx   = '0;
        case (in_op)
            OP_SET64: begin
                in_state = S_SETW;
            end
            OP_SETDCLR: begin
                in_bad   = !pos_ok || in_val[63:32] != '0 || (in_val == '0 && in_pos != '0);
                in_state = S_CLRW;
            end
            OP_ADDDIGIT: begin
                in_bad = !pos_ok || {1'b0, in_pos} != npos_reg;
                in_idx = AW'(in_pos);
            end
            OP_SHL: begin
                in_bad = sh_bad;
            end
            OP_SHR: begin
                in_bad = sh_bad;
                in_idx = top_reg;
            end
            OP_READ: begin
                in_bad = !pos_ok;
                in_idx = AW'(in_pos);
            end
            default: begin
                in_bad = 1'b0;
            end
        endcase
    end

    // digits above the top, and digit 0 before its first write, read as zero
    assign rd_eff = ((idx_reg > top_reg) || (idx_reg == '0 && !d0_ok_reg)) ? '0 : mem_rd;

    // read address: current digit when starting, neighbour while walking
    always_comb begin
        case (state_reg)
            S_ADDW, S_SHLW: mem_ra = idx_reg + AW'(1);
            S_SHRW:         mem_ra = idx_reg - AW'(1);
            default:        mem_ra = idx_reg;
        endcase
    end

    // digit operation for the walk in progress
    always_comb begin
        alu_ctrl.shamt = shamt_reg;
        case (op_reg)
            OP_SHL:  alu_ctrl.kind = ALU_SHL;
            OP_SHR:  alu_ctrl.kind = ALU_SHR;
            default: alu_ctrl.kind = ALU_ADD;
        endcase
    end

    // write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = alu_new;
        case (state_reg)
            S_SETW: begin
                mem_we = 1'b1;
                mem_wd = (idx_reg == '0) ? term_reg : hi_reg;
            end
            S_CLRW: begin
                mem_we = 1'b1;
                mem_wd = (idx_reg == AW'(pos_reg)) ? term_reg : '0;
            end
            S_ADDW, S_SHLW, S_SHRW: begin
                mem_we = 1'b1;
            end
            S_SHLX: begin
                mem_we = 1'b1;
                mem_wd = carry_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    wia_digit_ram #(
        .DEPTH (DIGITS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    wia_digit_alu u_alu (
        .ctrl      (alu_ctrl),
        .digit     (rd_eff),
        .term      (term_reg),
        .carry_in  (carry_reg),
        .digit_new (alu_new),
        .carry_out (alu_cout)
    );

    // sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            top_reg     <= '0;
            d0_ok_reg   <= 1'b0;
            scarry_reg  <= 1'b0;
            npos_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (mem_we && mem_wa == '0) begin
                d0_ok_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= in_op;
                        pos_reg   <= in_pos;
                        shamt_reg <= in_sh;
                        last_reg  <= s_tlast;
                        dout_reg  <= '0;
                        stat_reg  <= in_bad ? STAT_BAD : STAT_OK;
                        state_reg <= in_bad ? S_FIN : in_state;
                        carry_reg <= (in_op == OP_ADDDIGIT)
                                     ? {{(DIGIT_W-1){1'b0}}, scarry_reg} : '0;
                        term_reg  <= (in_op == OP_INC) ? DIGIT_W'(1) : in_val[31:0];
                        hi_reg    <= (in_op == OP_INC || in_op == OP_ADDDIGIT)
                                     ? '0 : in_val[63:32];
                        idx_reg   <= in_idx;
                        if (in_op != OP_ADDDIGIT) begin
                            scarry_reg <= 1'b0;
                            npos_reg   <= '0;
                        end
                    end
                end
                S_RD: begin
                    case (op_reg)
                        OP_SHL:  state_reg <= S_SHLW;
                        OP_SHR:  state_reg <= S_SHRW;
                        OP_READ: state_reg <= S_READW;
                        default: state_reg <= S_ADDW;
                    endcase
                end
                S_SETW: begin
                    if (idx_reg == '0) begin
                        idx_reg <= AW'(1);
                    end else begin
                        top_reg   <= (hi_reg != '0) ? AW'(1) : '0;
                        state_reg <= S_FIN;
                    end
                end
                S_CLRW: begin
                    if (idx_reg == AW'(pos_reg)) begin
                        top_reg   <= idx_reg;
                        state_reg <= S_FIN;
                    end else begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_ADDW: begin
                    if (idx_reg > top_reg && alu_new != '0) begin
                        top_reg <= idx_reg;
                    end
                    term_reg  <= hi_reg;
                    hi_reg    <= '0;
                    carry_reg <= alu_cout;
                    idx_reg   <= idx_reg + AW'(1);
                    // a stream digit that is not the last stops here
                    if (op_reg == OP_ADDDIGIT && !last_reg) begin
                        if (alu_cout[0] && idx_reg == IDX_MAX) begin
                            stat_reg <= STAT_OVF;
                        end
                        scarry_reg <= alu_cout[0] && (idx_reg != IDX_MAX);
                        npos_reg   <= NPOS_W'(idx_reg) + NPOS_W'(1);
                        state_reg  <= S_FIN;
                    end else if (idx_reg == IDX_MAX) begin
                        if (alu_cout[0]) begin
                            stat_reg <= STAT_OVF;
                        end
                        scarry_reg <= 1'b0;
                        npos_reg   <= '0;
                        state_reg  <= S_FIN;
                    end else if (!alu_cout[0] && hi_reg == '0) begin
                        scarry_reg <= 1'b0;
                        npos_reg   <= '0;
                        state_reg  <= S_FIN;
                    end
                end
                S_SHLW: begin
                    carry_reg <= alu_cout;
                    if (idx_reg == top_reg) begin
                        if (alu_cout == '0) begin
                            state_reg <= S_FIN;
                        end else if (top_reg == IDX_MAX) begin
                            stat_reg  <= STAT_OVF;
                            state_reg <= S_FIN;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_SHLX;
                        end
                    end else begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_SHLX: begin
                    top_reg   <= idx_reg;
                    state_reg <= S_FIN;
                end
                S_SHRW: begin
                    carry_reg <= alu_cout;
                    if (idx_reg == top_reg) begin
                        tz_reg <= (alu_new == '0);
                    end
                    if (idx_reg == '0) begin
                        // drop the top by one when its digit emptied
                        if (((idx_reg == top_reg) ? (alu_new == '0) : tz_reg)
                            && top_reg != '0) begin
                            top_reg <= top_reg - AW'(1);
                        end
                        state_reg <= S_FIN;
                    end else begin
                        idx_reg <= idx_reg - AW'(1);
                    end
                end
                S_READW: begin
                    dout_reg  <= rd_eff;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_digit_reg <= dout_reg;
                        m_top_reg   <= POS_W'(top_reg);
                        m_stat_reg  <= stat_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_top_reg, m_digit_reg};
    assign m_tuser  = m_stat_reg;

    // the store is only written while an item is being worked
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !mem_we)
        else $error("digit store written while idle");

    // one item at a time: input closes after each accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a rejected request never carries a digit
    a_bad_no_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_stat_reg == STAT_BAD |-> m_digit_reg == '0)
        else $error("rejected request returned a digit");

    // a finished result is not overwritten while it waits
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg && $stable(m_digit_reg)
        && $stable(m_stat_reg))
        else $error("waiting result overwritten");

    // the top index stays inside the store
    a_top_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(top_reg) < 32'(DIGITS))
        else $error("top index beyond store");

endmodule

`default_nettype wire

// ----- verif/tb_wide_integer_accumulator.sv -----
// Testbench for the wide integer accumulator: directed and random beats checked against a predictor.
`default_nettype none

module tb_wide_integer_accumulator
    import wia_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDIG        = DIGITS_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] digit;
        logic [6:0]  top;
        stat_t       status;
    } acc_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    wide_integer_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state
    logic [31:0] acc_digits [NDIG];
    int unsigned acc_top;
    logic [32:0] pend_carry;
    int unsigned next_pos;

    acc_result_t expected_results [$];
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned idle_cycles = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          sink_hold = 1'b0;
    int unsigned op_seen [8];

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] digit_at(int unsigned i);
        if (i >= NDIG || i > acc_top) return 32'd0;
        return acc_digits[i];
    endfunction

    // Add term and carry into digit i; return the carry out
    function automatic logic [32:0] add_into(int unsigned i, logic [63:0] term,
                                             logic [32:0] carry);
        logic [63:0] sum;
        sum = {32'd0, digit_at(i)} + term + {31'd0, carry};
        acc_digits[i] = sum[31:0];
        if (i > acc_top && sum[31:0] != 0) acc_top = i;
        return sum[63:32];
    endfunction

    function automatic stat_t add_wide64(logic [63:0] v);
        logic [32:0] carry;
        logic [63:0] term;
        carry = '0;
        for (int unsigned i = 0; i < NDIG; i++) begin
            term = (i == 0) ? {32'd0, v[31:0]} : (i == 1) ? {32'd0, v[63:32]} : 64'd0;
            if (i > acc_top && term == 0 && carry == 0) return STAT_OK;
            carry = add_into(i, term, carry);
        end
        return (carry != 0) ? STAT_OVF : STAT_OK;
    endfunction

    function automatic stat_t carry_up(int unsigned from, logic [32:0] carry);
        int unsigned i;
        i = from;
        while (carry != 0 && i < NDIG) begin
            carry = add_into(i, 64'd0, carry);
            i++;
        end
        return (carry != 0) ? STAT_OVF : STAT_OK;
    endfunction

    function automatic acc_result_t predict_accumulator(op_t op, int unsigned pos,
            logic [63:0] val, bit last, int unsigned sh);
        acc_result_t r;
        logic [63:0] d;
        logic [31:0] carry;
        logic [32:0] c;
        r.digit = '0;
        r.status = STAT_OK;
        if (op != OP_ADDDIGIT) begin
            pend_carry = '0;
            next_pos = 0;
        end
        case (op)
            OP_SET64: begin
                acc_digits[0] = val[31:0];
                acc_digits[1] = val[63:32];
                acc_top = (val[63:32] != 0) ? 1 : 0;
            end
            OP_SETDCLR: begin
                if (pos >= NDIG || val[63:32] != 0 || (val == 0 && pos != 0)) begin
                    r.status = STAT_BAD;
                end else begin
                    for (int unsigned i = 0; i < pos; i++) acc_digits[i] = '0;
                    acc_digits[pos] = val[31:0];
                    acc_top = pos;
                end
            end
            OP_ADD64: r.status = add_wide64(val);
            OP_INC:   r.status = add_wide64(64'd1);
            OP_ADDDIGIT: begin
                if (pos >= NDIG || pos != next_pos) begin
                    r.status = STAT_BAD;
                end else begin
                    c = add_into(pos, {32'd0, val[31:0]}, pend_carry);
                    if (last) begin
                        r.status = carry_up(pos + 1, c);
                        pend_carry = '0;
                        next_pos = 0;
                    end else begin
                        if (c != 0 && pos + 1 >= NDIG) begin
                            r.status = STAT_OVF;
                            c = '0;
                        end
                        pend_carry = c;
                        next_pos = pos + 1;
                    end
                end
            end
            OP_SHL: begin
                if (sh > 32) begin
                    r.status = STAT_BAD;
                end else begin
                    carry = '0;
                    for (int unsigned i = 0; i <= acc_top && i < NDIG; i++) begin
                        d = {32'd0, acc_digits[i]} << sh;
                        acc_digits[i] = d[31:0] | carry;
                        carry = d[63:32];
                    end
                    if (carry != 0) begin
                        if (acc_top + 1 >= NDIG) begin
                            r.status = STAT_OVF;
                        end else begin
                            acc_top++;
                            acc_digits[acc_top] = carry;
                        end
                    end
                end
            end
            OP_SHR: begin
                if (sh > 32) begin
                    r.status = STAT_BAD;
                end else begin
                    carry = '0;
                    for (int i = int'(acc_top); i >= 0; i--) begin
                        d = {acc_digits[i], 32'd0} >> sh;
                        acc_digits[i] = d[63:32] | carry;
                        carry = d[31:0];
                    end
                    if (acc_digits[acc_top] == 0 && acc_top > 0) acc_top--;
                end
            end
            default: begin
                if (pos >= NDIG) r.status = STAT_BAD;
                else r.digit = digit_at(pos);
            end
        endcase
        r.top = acc_top[6:0];
        return r;
    endfunction

    // Drive one beat at the falling edge; predict when accepted.
    // Valid stays up on return so that the next beat can follow at once.
    task automatic send_beat(op_t op, int unsigned pos, logic [63:0] val,
                             bit last, int unsigned sh);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'd0, sh[5:0], val, pos[6:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_accumulator(op, pos, val, last, sh));
        op_seen[op]++;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_digit();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // Ready side: random bursts of back-pressure, or a long hold
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold) m_tready <= 1'b0;
            else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("result %0d: %s got 0x%0h expected 0x%0h", result_count, what, got, want);
    endtask

    // Compare each accepted result beat with the oldest expectation
    initial begin
        acc_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.digit)
                        report_mismatch("digit", m_tdata[31:0], want.digit);
                    if (m_tdata[38:32] !== want.top)
                        report_mismatch("top", m_tdata[38:32], want.top);
                    if (m_tdata[39] !== 1'b0) report_mismatch("pad", m_tdata[39], 0);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                end
                result_count++;
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic test_set_and_read();
        send_beat(OP_READ, 0, 0, 0, 0);
        send_beat(OP_SET64, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        send_beat(OP_READ, 1, 0, 0, 0);
        send_beat(OP_READ, 5, 0, 0, 0);
        send_beat(OP_SETDCLR, 127, 32'h1, 0, 0);
        send_beat(OP_READ, 127, 0, 0, 0);
        send_beat(OP_SETDCLR, 3, 0, 0, 0);
        send_beat(OP_SETDCLR, 0, 0, 0, 0);
        send_beat(OP_SETDCLR, 2, 64'h1_0000_0000, 0, 0);
    endtask

    task automatic test_add_and_overflow();
        send_beat(OP_SETDCLR, 127, 32'hFFFF_FFFF, 0, 0);
        send_beat(OP_SETDCLR, 127, 32'hFFFF_FFFF, 0, 0);
        for (int i = 0; i < 3; i++) send_beat(OP_SHR, 0, 0, 0, 0);
        send_beat(OP_SET64, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        send_beat(OP_INC, 0, 0, 0, 0);
        send_beat(OP_ADD64, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        send_beat(OP_SHL, 0, 0, 0, 32);
        send_beat(OP_SHL, 0, 0, 0, 33);
        send_beat(OP_SHR, 0, 0, 0, 63);
        send_beat(OP_SHR, 0, 0, 0, 32);
    endtask

    task automatic test_wide_stream();
        // Set only the top digit, then send out-of-order and interrupted digit streams
        send_beat(OP_SETDCLR, 127, 32'hFFFF_FFFF, 0, 0);
        send_beat(OP_ADDDIGIT, 1, 5, 0, 0);
        send_beat(OP_ADDDIGIT, 0, 32'hFFFF_FFFF, 0, 0);
        send_beat(OP_ADDDIGIT, 1, 32'hFFFF_FFFF, 1, 0);
        send_beat(OP_ADDDIGIT, 0, 32'hFFFF_FFFF, 0, 0);
        send_beat(OP_READ, 0, 0, 0, 0);
        send_beat(OP_ADDDIGIT, 1, 1, 1, 0);
    endtask

    task automatic test_stream_top_overflow();
        send_beat(OP_SETDCLR, 127, 32'hFFFF_FFFF, 0, 0);
        for (int p = 0; p < NDIG; p++)
            send_beat(OP_ADDDIGIT, p, (p == 127) ? 32'h1 : 32'd0, 0, 0);
        send_beat(OP_ADDDIGIT, 0, 1, 1, 0);
    endtask

    // Mostly well-formed streams with random content, plus noise
    task automatic test_random(int unsigned count);
        int unsigned n;
        int unsigned len;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NDIG)
                                                      : $urandom_range(1, 6);
                    for (int unsigned p = 0; p < len; p++) begin
                        send_beat(OP_ADDDIGIT, ($urandom_range(0, 40) == 0) ? $urandom_range(0, 127) : p,
                                  rand64(), (p == len - 1), $urandom_range(0, 63));
                        n++;
                    end
                end
                3: send_beat(OP_SET64, $urandom_range(0, 127), rand64(), $urandom_range(0, 1),
                             $urandom_range(0, 63));
                4: send_beat(OP_SETDCLR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                             : $urandom_range(0, 8), ($urandom_range(0, 9) == 0) ? rand64()
                             : {32'd0, rand_digit()}, $urandom_range(0, 1), $urandom_range(0, 63));
                5: send_beat(OP_ADD64, $urandom_range(0, 127),
                             {rand_digit(), rand_digit()}, $urandom_range(0, 1),
                             $urandom_range(0, 63));
                6: send_beat(OP_INC, $urandom_range(0, 127), rand64(), $urandom_range(0, 1),
                             $urandom_range(0, 63));
                7: send_beat(($urandom_range(0, 1) ? OP_SHL : OP_SHR), $urandom_range(0, 127),
                             rand64(), $urandom_range(0, 1),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63)
                                                         : $urandom_range(0, 32));
                default: send_beat(OP_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                   : $urandom_range(0, acc_top + 1), rand64(),
                                   $urandom_range(0, 1), $urandom_range(0, 63));
            endcase
            n++;
        end
    endtask

    // Hold the receiver off for a long stretch while beats keep coming
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (600) @(posedge aclk);
                sink_hold = 1'b0;
            end
            test_random(30);
        join
    endtask

    initial begin
        int unsigned guard;
        for (int i = 0; i < NDIG; i++) acc_digits[i] = '0;
        acc_top = 0;
        pend_carry = '0;
        next_pos = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_set_and_read();
        test_add_and_overflow();
        test_wide_stream();
        test_stream_top_overflow();
        test_random(1600);
        test_backpressure();
        // Final stretch with no idling on either side
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        test_random(300);
        s_tvalid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < STALL_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);

        $display("Covered %0d results: set64 %0d, setdigitclear %0d, add64 %0d, increment %0d,",
                 result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("adddigit %0d, shiftleft %0d, shiftright %0d, readdigit %0d, with a long stall",
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
